// ===== rtl/swm_pkg.sv =====
// Shared definitions for the sliding window median filter.
// Holds fixed field widths, the reset window length and the cell-row command bundle.
// No dependencies.
`default_nettype none

package swm_pkg;

  // Fixed port widths
  localparam int CFG_W = 6;
  localparam int IN_W  = 32;
  localparam int OUT_W = 33;

  // Window length register value after reset
  localparam logic [CFG_W-1:0] WIN_RST = 6'd3;

  // Command broadcast from the control logic to every cell
  typedef struct packed {
    logic en;       // accepted transaction: update the row
    logic clr;      // empty the row (window length write)
    logic restart;  // treat current contents as empty before insertion
    logic full;     // window full: drop the oldest entry this cycle
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sliding_window_median.sv =====
// Sliding window median filter, top level.
// Depends on swm_pkg, swm_chain (swm_cell) and swm_median.
//
// Usage:
//   Input channel (in_valid/in_stall, in_sample, in_restart): one sample per
//   transaction; in_restart empties the window before the sample goes in.
//   Result channel (out_valid/out_stall, out_median_twice): twice the window
//   median, one result per sample once the window holds window_size samples.
//   Config (cfg_we, cfg_data): writes window_size (0 acts as 1, values above
//   WINDOW_MAX act as WINDOW_MAX) and empties the window. Write only when idle.
// Timing:
//   Throughput is one sample per cycle while in_stall is low: the whole sorted
//   row of cells (insert the new sample, drop the oldest by age tag) updates at once.
//   out_valid follows the input transaction through the cell row, which updates
//   at the accepting edge, then the output register, which loads once it is empty or draining.
// Reset:
//   Synchronous, active low; window empty, window_size = 3.
// Backpressure:
//   While out_stall holds a result in the output register, one more result
//   waits in the cell row; further input is stalled until the output drains.
`default_nettype none

module sliding_window_median #(
  parameter int WINDOW_MAX  = 32,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [swm_pkg::IN_W-1:0]            in_sample,
  input  wire logic                                in_restart,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [swm_pkg::OUT_W-1:0]         out_median_twice,
  input  wire logic                                cfg_we,
  input  wire logic [swm_pkg::CFG_W-1:0]           cfg_data
);

  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);

  // Effective window length from the register value
  function automatic logic [CW-1:0] clamp_win(input logic [swm_pkg::CFG_W-1:0] v);
    logic [CW-1:0] w;
    if (v == '0) begin
      w = CW'(1);
    end else if (32'(v) > 32'(WINDOW_MAX)) begin
      w = CW'(WINDOW_MAX);
    end else begin
      w = CW'(v);
    end
    return w;
  endfunction

  logic [CW-1:0] win_r, win_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          res_pend_r, res_pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic signed [swm_pkg::OUT_W-1:0] out_med_r;

  logic                   accept, move, produce, full;
  logic [CW-1:0]          n_eff, cnt_new;
  logic signed [SAMPLE_BITS-1:0] s;
  swm_pkg::cmd_t          cmd;
  logic [IW-1:0]          del_age, hi_idx, lo_idx;
  logic signed [SAMPLE_BITS-1:0] row_val [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  row_vld;
  logic signed [swm_pkg::OUT_W-1:0] med_sum;

  // Handshake: the cell row holds a pending result until the output takes it
  assign move     = res_pend_r && (!out_valid_r || !out_stall);
  assign in_stall = res_pend_r && !move;
  assign accept   = in_valid && !in_stall;

  // Occupancy bookkeeping
  assign s       = in_sample[SAMPLE_BITS-1:0];
  assign n_eff   = in_restart ? '0 : cnt_r;
  assign full    = (n_eff == win_r);
  assign cnt_new = full ? win_r : n_eff + CW'(1);
  assign produce = (cnt_new == win_r);
  assign del_age = IW'(win_r - CW'(1));

  always_comb begin
    cmd.en      = accept;
    cmd.clr     = cfg_we;
    cmd.restart = accept && in_restart;
    cmd.full    = accept && full;
  end

  swm_chain #(
    .WM(WINDOW_MAX),
    .SB(SAMPLE_BITS),
    .AW(IW)
  ) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .s      (s),
    .del_age(del_age),
    .val_o  (row_val),
    .vld_o  (row_vld)
  );

  // Middle pair of the sorted row
  assign hi_idx = IW'(win_r >> 1);
  assign lo_idx = win_r[0] ? hi_idx : hi_idx - IW'(1);

  swm_median #(
    .WM(WINDOW_MAX),
    .SB(SAMPLE_BITS),
    .IW(IW)
  ) u_median (
    .val   (row_val),
    .hi_idx(hi_idx),
    .lo_idx(lo_idx),
    .sum_o (med_sum)
  );

  // Next-state for control registers
  always_comb begin
    win_nxt = cfg_we ? clamp_win(cfg_data) : win_r;

    cnt_nxt = cnt_r;
    if (cfg_we) begin
      cnt_nxt = '0;
    end else if (accept) begin
      cnt_nxt = cnt_new;
    end

    res_pend_nxt = res_pend_r;
    if (accept) begin
      res_pend_nxt = produce;
    end else if (move) begin
      res_pend_nxt = 1'b0;
    end

    out_valid_nxt = move || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= clamp_win(swm_pkg::WIN_RST);
      cnt_r       <= '0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      cnt_r       <= cnt_nxt;
      res_pend_r  <= res_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (move) begin
      out_med_r <= med_sum;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median_twice = out_med_r;

  // Checks
  a_stall_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> res_pend_r)
    else $error("input stalled with no pending result");

  a_cnt_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= win_r)
    else $error("fill count above window length");

  a_row_matches_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(row_vld) == 32'(cnt_r))
    else $error("occupied cells disagree with fill count");

  a_result_full: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && produce && !cfg_we) |=> (res_pend_r && cnt_r == win_r))
    else $error("result issued without a full window");

  a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (cnt_r == '0 && row_vld == '0))
    else $error("window not emptied by config write");

endmodule

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// One cell of the sorted row: holds a sample, its age and a valid bit.
// Updates from its own value, a neighbor's or the new sample. Depends on swm_pkg.
`default_nettype none

module swm_cell #(
  parameter int SB = 32,
  parameter int AW = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire swm_pkg::cmd_t        cmd,
  input  wire logic signed [SB-1:0] s,
  input  wire logic [AW-1:0]        del_age,
  // deletion has happened at or below the left neighbor / this cell
  input  wire logic                 pfx_l,
  input  wire logic                 pfx_s,
  // own valid, already masked by restart
  input  wire logic                 cur_vld,
  input  wire logic signed [SB-1:0] l_val,
  input  wire logic [AW-1:0]        l_age,
  input  wire logic                 l_vld,
  input  wire logic signed [SB-1:0] r_val,
  input  wire logic [AW-1:0]        r_age,
  input  wire logic                 r_vld,
  output logic signed [SB-1:0]      val_o,
  output logic [AW-1:0]             age_o,
  output logic                      vld_o,
  output logic                      del_o
);

  logic signed [SB-1:0] val_r, val_nxt;
  logic [AW-1:0]        age_r, age_nxt;
  logic                 vld_r, vld_nxt;

  logic signed [SB-1:0] dl_val, ds_val;
  logic [AW-1:0]        dl_age, ds_age;
  logic                 dl_vld, ds_vld;
  logic                 gt_l, gt_s;

  // This cell holds the oldest sample of a full window
  assign del_o = vld_r && cmd.full && (age_r == del_age);

  // Row after the oldest entry is taken out, then insertion of s
  always_comb begin
    dl_val = pfx_l ? val_r   : l_val;
    dl_age = pfx_l ? age_r   : l_age;
    dl_vld = pfx_l ? cur_vld : l_vld;
    ds_val = pfx_s ? r_val   : val_r;
    ds_age = pfx_s ? r_age   : age_r;
    ds_vld = pfx_s ? r_vld   : cur_vld;

    // empty slots act as larger than any sample
    gt_l = !dl_vld || (dl_val > s);
    gt_s = !ds_vld || (ds_val > s);

    if (!gt_s) begin
      val_nxt = ds_val;
      age_nxt = ds_age + AW'(1);
      vld_nxt = ds_vld;
    end else if (gt_l) begin
      val_nxt = dl_val;
      age_nxt = dl_age + AW'(1);
      vld_nxt = dl_vld;
    end else begin
      val_nxt = s;
      age_nxt = '0;
      vld_nxt = 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.en && !cmd.clr) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (cmd.clr) begin
      vld_r <= 1'b0;
    end else if (cmd.en) begin
      vld_r <= vld_nxt;
    end
  end

  assign val_o = val_r;
  assign age_o = age_r;
  assign vld_o = vld_r;

endmodule

`default_nettype wire

// ===== rtl/swm_chain.sv =====
// Row of swm_cell instances forming the sorted window store.
// Wires neighbors, masks occupancy on restart, forms the deletion prefix. Depends on swm_pkg, swm_cell.
`default_nettype none

module swm_chain #(
  parameter int WM = 32,
  parameter int SB = 32,
  parameter int AW = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire swm_pkg::cmd_t        cmd,
  input  wire logic signed [SB-1:0] s,
  input  wire logic [AW-1:0]        del_age,
  output logic signed [SB-1:0]      val_o [WM],
  output logic [WM-1:0]             vld_o
);

  logic signed [SB-1:0] val [WM];
  logic [AW-1:0]        age [WM];
  logic [WM-1:0]        vld;
  logic [WM-1:0]        mvld;
  logic [WM-1:0]        del;
  logic [WM-1:0]        pfx;

  logic signed [SB-1:0] l_val [WM];
  logic [AW-1:0]        l_age [WM];
  logic [WM-1:0]        l_vld;
  logic signed [SB-1:0] r_val [WM];
  logic [AW-1:0]        r_age [WM];
  logic [WM-1:0]        r_vld;
  logic [WM-1:0]        pfx_l;

  // A restart empties the row before insertion
  assign mvld = vld & ~{WM{cmd.restart}};

  for (genvar j = 0; j < WM; j++) begin : g_cell
    localparam logic [WM-1:0] LOW_MASK = {WM{1'b1}} >> (WM - 1 - j);

    // deletion at or below this cell
    assign pfx[j] = |(del & LOW_MASK);

    // left neighbor; the head sees a smallest-possible occupied entry
    if (j == 0) begin : g_head
      assign l_val[j] = {1'b1, {(SB-1){1'b0}}};
      assign l_age[j] = '0;
      assign l_vld[j] = 1'b1;
      assign pfx_l[j] = 1'b0;
    end else begin : g_mid_l
      assign l_val[j] = val[j-1];
      assign l_age[j] = age[j-1];
      assign l_vld[j] = mvld[j-1];
      assign pfx_l[j] = pfx[j-1];
    end

    // right neighbor; past the tail is empty
    if (j == WM - 1) begin : g_tail
      assign r_val[j] = '0;
      assign r_age[j] = '0;
      assign r_vld[j] = 1'b0;
    end else begin : g_mid_r
      assign r_val[j] = val[j+1];
      assign r_age[j] = age[j+1];
      assign r_vld[j] = mvld[j+1];
    end

    swm_cell #(
      .SB(SB),
      .AW(AW)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .s      (s),
      .del_age(del_age),
      .pfx_l  (pfx_l[j]),
      .pfx_s  (pfx[j]),
      .cur_vld(mvld[j]),
      .l_val  (l_val[j]),
      .l_age  (l_age[j]),
      .l_vld  (l_vld[j]),
      .r_val  (r_val[j]),
      .r_age  (r_age[j]),
      .r_vld  (r_vld[j]),
      .val_o  (val[j]),
      .age_o  (age[j]),
      .vld_o  (vld[j]),
      .del_o  (del[j])
    );

    assign val_o[j] = val[j];
  end

  assign vld_o = vld;

endmodule

`default_nettype wire

// ===== rtl/swm_median.sv =====
// Median tap of the sorted row: picks the middle pair and adds them.
// Odd windows pick the same entry twice. Depends on swm_pkg.
`default_nettype none

module swm_median #(
  parameter int WM = 32,
  parameter int SB = 32,
  parameter int IW = 5
) (
  input  wire logic signed [SB-1:0]          val [WM],
  input  wire logic [IW-1:0]                 hi_idx,
  input  wire logic [IW-1:0]                 lo_idx,
  output logic signed [swm_pkg::OUT_W-1:0]   sum_o
);

  localparam int EXT = swm_pkg::OUT_W - SB;

  logic [SB-1:0] hi_val, lo_val;

  // One-hot AND-OR select across the row
  always_comb begin
    hi_val = '0;
    lo_val = '0;
    for (int j = 0; j < WM; j++) begin
      if (IW'(j) == hi_idx) hi_val = hi_val | val[j];
      if (IW'(j) == lo_idx) lo_val = lo_val | val[j];
    end
  end

  assign sum_o = $signed({{EXT{hi_val[SB-1]}}, hi_val})
               + $signed({{EXT{lo_val[SB-1]}}, lo_val});

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for sliding_window_median: directed rows, then random
// streams checked against an in-bench sorted-window predictor.
// Depends on swm_pkg and the sliding_window_median RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_DEPTH    = 32;
  localparam int PHASE_ITEMS  = 93;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int CFG_SETTLE   = 4;

  // Clock and DUT ports
  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [swm_pkg::IN_W-1:0]         in_sample = '0;
  logic                             in_restart = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [swm_pkg::OUT_W-1:0] out_median_twice;
  logic                             cfg_we = 1'b0;
  logic [swm_pkg::CFG_W-1:0]        cfg_data = '0;

  // Idle rates in percent, changed per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int err_count = 0;
  int samples_sent = 0;
  int medians_seen = 0;
  int window_writes = 0;

  // Expected results, oldest first
  logic signed [swm_pkg::OUT_W-1:0] expected_medians[$];

  // Predictor state: arrival ring, sorted copy, fill level, oldest slot, length register
  logic signed [swm_pkg::IN_W-1:0] win_ring[WIN_DEPTH];
  logic signed [swm_pkg::IN_W-1:0] win_sorted[WIN_DEPTH];
  int unsigned                     win_fill;
  int unsigned                     win_oldest;
  logic [swm_pkg::CFG_W-1:0]       win_len_reg;

  // Directed row: optional length write before the sample, optional typed-in median
  typedef struct {
    bit                         wr_len;
    logic [swm_pkg::CFG_W-1:0]  len;
    logic [swm_pkg::IN_W-1:0]   sample;
    bit                         restart;
    bit                         typed;
    logic [swm_pkg::OUT_W-1:0]  median;
  } directed_row_t;

  directed_row_t directed_rows[17];

  sliding_window_median dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median_twice (out_median_twice),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Length in use: zero acts as one, large values clamp to the depth
  function automatic int unsigned active_len();
    int unsigned w;
    w = win_len_reg;
    if (w == 0) w = 1;
    if (w > WIN_DEPTH) w = WIN_DEPTH;
    return w;
  endfunction

  // Insert one sample; returns 1 with twice the median once the window is full
  function automatic bit window_median_step(
      input logic signed [swm_pkg::IN_W-1:0] s, input bit restart,
      output logic signed [swm_pkg::OUT_W-1:0] median);
    int unsigned w;
    int          pos;
    logic signed [swm_pkg::IN_W-1:0] gone;
    w = active_len();
    median = '0;
    if (restart || win_fill >= w) begin
      win_fill = 0;
      win_oldest = 0;
    end
    win_ring[(win_oldest + win_fill) % WIN_DEPTH] = s;
    pos = win_fill;
    while (pos > 0 && win_sorted[pos-1] > s) begin
      win_sorted[pos] = win_sorted[pos-1];
      pos--;
    end
    win_sorted[pos] = s;
    win_fill++;
    if (win_fill < w) return 1'b0;
    if (w % 2 == 1) median = win_sorted[w/2] + win_sorted[w/2];
    else median = win_sorted[w/2-1] + win_sorted[w/2];
    // drop exactly one copy of the oldest sample
    gone = win_ring[win_oldest];
    pos = 0;
    while (pos < win_fill && win_sorted[pos] != gone) pos++;
    while (pos + 1 < win_fill) begin
      win_sorted[pos] = win_sorted[pos+1];
      pos++;
    end
    win_fill--;
    win_oldest = (win_oldest + 1) % WIN_DEPTH;
    return 1'b1;
  endfunction

  // Mix of full-range, clustered (many duplicates) and extreme samples
  function automatic logic [swm_pkg::IN_W-1:0] pick_sample();
    logic [swm_pkg::IN_W-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = $urandom;
      4, 5, 6, 7: s = $urandom_range(0, 8) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0: s = 32'h8000_0000;
          1: s = 32'h7FFF_FFFF;
          2: s = 32'h0000_0000;
          default: s = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return s;
  endfunction

  // Send one sample transaction; called and returns at a falling edge
  task automatic push_sample(input logic [swm_pkg::IN_W-1:0] s, input bit restart,
                             input bit typed,
                             input logic [swm_pkg::OUT_W-1:0] typed_median);
    logic signed [swm_pkg::OUT_W-1:0] median;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_sample  <= s;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    if (window_median_step(s, restart, median)) begin
      if (typed) median = typed_median;
      expected_medians = {expected_medians, median};
    end
    @(negedge clk);
  endtask

  // Length write once the block has drained; the window empties
  task automatic write_window(input logic [swm_pkg::CFG_W-1:0] len);
    in_valid <= 1'b0;
    while (expected_medians.size() != 0) @(negedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_len_reg = len;
    win_fill    = 0;
    win_oldest  = 0;
    window_writes++;
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      medians_seen++;
      if (expected_medians.size() == 0) begin
        $error("unexpected transaction: median_twice %0d", out_median_twice);
        err_count++;
      end else begin
        if (out_median_twice !== expected_medians[0]) begin
          $error("median_twice mismatch: expected %0d, got %0d",
                 expected_medians[0], out_median_twice);
          err_count++;
        end
        void'(expected_medians.pop_front());
      end
    end
  end

  // Hard stop
  initial begin
    #5_000_000;
    $display("sliding_window_median regression: fail");
    $finish;
  end

  // Stimulus
  initial begin
    logic [swm_pkg::CFG_W-1:0] phase_len[9];
    int                        drain_wait;

    directed_rows = '{
      // reset length 3, duplicates in the window
      '{0, 6'd0,  32'd5,          0, 0, 33'h0},
      '{0, 6'd0,  32'hFFFF_FFF9,  0, 0, 33'h0},
      '{0, 6'd0,  32'd5,          0, 0, 33'h0},
      '{0, 6'd0,  32'd5,          0, 0, 33'h0},
      // restart mid-stream
      '{0, 6'd0,  32'd100,        1, 0, 33'h0},
      '{0, 6'd0,  32'd1,          0, 0, 33'h0},
      '{0, 6'd0,  32'd2,          0, 0, 33'h0},
      // length zero behaves as one: result is twice the sample
      '{1, 6'd0,  32'h7FFF_FFFF,  0, 1, 33'h0_FFFF_FFFE},
      '{0, 6'd0,  32'h8000_0000,  0, 1, 33'h1_0000_0000},
      '{0, 6'd0,  32'hFFFF_FFFF,  0, 1, 33'h1_FFFF_FFFE},
      '{0, 6'd0,  32'h0000_0000,  1, 1, 33'h0},
      '{0, 6'd0,  32'h5555_5555,  0, 1, 33'h0_AAAA_AAAA},
      '{0, 6'd0,  32'hAAAA_AAAA,  0, 1, 33'h1_5555_5554},
      // even length: sum of the two middle samples at the extremes
      '{1, 6'd2,  32'h7FFF_FFFF,  0, 0, 33'h0},
      '{0, 6'd0,  32'h7FFF_FFFF,  0, 1, 33'h0_FFFF_FFFE},
      '{0, 6'd0,  32'h8000_0000,  0, 1, 33'h1_FFFF_FFFF},
      '{0, 6'd0,  32'h8000_0000,  0, 1, 33'h1_0000_0000}
    };
    phase_len = '{6'd32, 6'd63, 6'd1, 6'd2, 6'd3, 6'd7, 6'd16, 6'd33,
                  6'($urandom_range(0, 63))};

    // Reset and predictor reset
    win_len_reg = swm_pkg::WIN_RST;
    win_fill    = 0;
    win_oldest  = 0;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_ring[i]   = '0;
      win_sorted[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].wr_len) write_window(directed_rows[i].len);
      push_sample(directed_rows[i].sample, directed_rows[i].restart,
                  directed_rows[i].typed, directed_rows[i].median);
    end

    // Random phases: receiver-heavy stalling, sender-heavy idling, then none
    for (int p = 0; p < 9; p++) begin
      write_window(phase_len[p]);
      case (p / 3)
        0: begin send_idle_pct = 23; recv_stall_pct = 67; end
        1: begin send_idle_pct = 67; recv_stall_pct = 23; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++)
        push_sample(pick_sample(), ($urandom_range(0, 99) < 2), 1'b0, '0);
    end

    // Drain
    in_valid <= 1'b0;
    drain_wait = 0;
    while (expected_medians.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (8) @(negedge clk);
    if (expected_medians.size() != 0) begin
      $error("%0d expected median_twice transactions never arrived",
             expected_medians.size());
      err_count++;
    end

    $display("Covered %0d samples and %0d medians across %0d window length writes,",
             samples_sent, medians_seen, window_writes);
    $display("with restarts, duplicate samples, extremes and three idle/stall mixes.");
    if (err_count == 0) begin
      $display("sliding_window_median regression: pass");
    end else begin
      $display("sliding_window_median regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_chain.sv
rtl/swm_median.sv
rtl/sliding_window_median.sv
tb/testbench.sv
